// ----- rtl/rhc_pkg.sv -----
`timescale 1ns / 1ps

package rhc_pkg;

	localparam int CHAN_W      = 8;
	localparam int FRAC_W      = 16;
	localparam int SPAN_W      = 11;
	localparam int BITS_PER_ST = 4;
	localparam int DIV_STAGES  = FRAC_W / BITS_PER_ST;

	// Sector of the largest channel, red tested first, then green
	localparam logic [1:0] SECT_RED   = 2'd0;
	localparam logic [1:0] SECT_GREEN = 2'd1;
	localparam logic [1:0] SECT_BLUE  = 2'd2;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [FRAC_W-1:0] hue;
		logic [FRAC_W-1:0] saturation;
		logic [CHAN_W-1:0] brightness;
		logic              hue_valid;
	} hsv_t;

	// Working set of the two long divisions, carried through the divider stages
	typedef struct packed {
		logic [SPAN_W-1:0] hue_rem;
		logic [SPAN_W-1:0] span;
		logic [FRAC_W-1:0] hue_quo;
		logic [CHAN_W-1:0] sat_rem;
		logic [CHAN_W-1:0] max_val;
		logic [FRAC_W-1:0] sat_quo;
		logic              hue_valid;
		logic              sat_full;
		logic              black;
	} div_t;

endpackage

// ----- rtl/rhc_div_stage.sv -----
`timescale 1ns / 1ps

module rhc_div_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  rhc_pkg::div_t in_data,
	output logic          out_valid,
	output rhc_pkg::div_t out_data
);
	import rhc_pkg::*;

	logic  valid_sx;
	div_t  data_sx;
	div_t  next;

	// Four restoring steps of each division: shift, compare, subtract
	always_comb begin
		logic [SPAN_W:0] hr;
		logic [CHAN_W:0] sr;
		next = in_data;
		for (int i = 0; i < BITS_PER_ST; i++) begin
			hr = {next.hue_rem, 1'b0};
			if (hr >= {1'b0, next.span}) begin
				hr = hr - {1'b0, next.span};
				next.hue_quo = {next.hue_quo[FRAC_W-2:0], 1'b1};
			end else begin
				next.hue_quo = {next.hue_quo[FRAC_W-2:0], 1'b0};
			end
			next.hue_rem = hr[SPAN_W-1:0];

			sr = {next.sat_rem, 1'b0};
			if (sr >= {1'b0, next.max_val}) begin
				sr = sr - {1'b0, next.max_val};
				next.sat_quo = {next.sat_quo[FRAC_W-2:0], 1'b1};
			end else begin
				next.sat_quo = {next.sat_quo[FRAC_W-2:0], 1'b0};
			end
			next.sat_rem = sr[CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sx <= 1'b0;
		end else begin
			valid_sx <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_sx <= next;
	end

	assign out_valid = valid_sx;
	assign out_data  = data_sx;

endmodule

// ----- rtl/rgb_to_hsv_convert.sv -----
`timescale 1ns / 1ps

// RGB to HSV pixel converter. One pixel enters on every clock at which start is
// high; busy never rises, and each result is marked by done for one cycle, in
// input order. There is no way to hold a result off: the receiver must take it
// in the cycle that done is high. The pipeline holds the two 16-bit long
// divisions (hue and saturation), done side by side at four quotient bits per
// pipeline stage, after one stage for min/max and sector and one for the hue
// numerator and divisor setup, and followed by the output register.
// Black and grey pixels give hue 0 with hue_valid low.
module rgb_to_hsv_convert (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  rhc_pkg::pixel_t pixel,
	output logic            done,
	output rhc_pkg::hsv_t   result
);
	import rhc_pkg::*;

	// stage 1: largest, smallest, sector and channel difference
	logic              v_s1;
	logic [CHAN_W-1:0] max_s1;
	logic [CHAN_W-1:0] min_s1;
	logic [1:0]        sect_s1;
	logic signed [CHAN_W:0] diff_s1;

	logic [CHAN_W-1:0] mx;
	logic [CHAN_W-1:0] mn;
	logic [1:0]        sect;
	logic signed [CHAN_W:0] diff;

	always_comb begin
		mx = pixel.red;
		if (pixel.green > mx) mx = pixel.green;
		if (pixel.blue > mx) mx = pixel.blue;
		mn = pixel.red;
		if (pixel.green < mn) mn = pixel.green;
		if (pixel.blue < mn) mn = pixel.blue;
		if (pixel.red == mx) begin
			sect = SECT_RED;
			diff = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
		end else if (pixel.green == mx) begin
			sect = SECT_GREEN;
			diff = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
		end else begin
			sect = SECT_BLUE;
			diff = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		max_s1  <= mx;
		min_s1  <= mn;
		sect_s1 <= sect;
		diff_s1 <= diff;
	end

	// stage 2: delta, hue numerator with wrap, divisor span = 6 * delta
	logic [CHAN_W-1:0]   delta;
	logic [CHAN_W+1:0]   off_delta;
	logic [SPAN_W-1:0]   span;
	logic signed [SPAN_W:0] n_raw;
	logic signed [SPAN_W:0] n_wrap;
	logic                v_s2;
	div_t                div_s2;

	always_comb begin
		delta = max_s1 - min_s1;
		span  = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
		case (sect_s1)
			SECT_RED:   off_delta = '0;
			SECT_GREEN: off_delta = {1'b0, delta, 1'b0};
			SECT_BLUE:  off_delta = {delta, 2'b00};
			default:    off_delta = '0;
		endcase
		n_raw  = $signed({2'b00, off_delta}) + {{(SPAN_W-CHAN_W){diff_s1[CHAN_W]}}, diff_s1};
		n_wrap = n_raw[SPAN_W] ? n_raw + $signed({1'b0, span}) : n_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		div_s2.hue_rem   <= n_wrap[SPAN_W-1:0];
		div_s2.span      <= span;
		div_s2.hue_quo   <= '0;
		div_s2.sat_rem   <= delta;
		div_s2.max_val   <= max_s1;
		div_s2.sat_quo   <= '0;
		div_s2.hue_valid <= (delta != '0);
		div_s2.sat_full  <= (min_s1 == '0) && (max_s1 != '0);
		div_s2.black     <= (max_s1 == '0);
	end

	// divider stages
	logic [DIV_STAGES:0] div_v;
	div_t                div_d [DIV_STAGES+1];

	assign div_v[0] = v_s2;
	assign div_d[0] = div_s2;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		rhc_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_v[k]),
			.in_data   (div_d[k]),
			.out_valid (div_v[k+1]),
			.out_data  (div_d[k+1])
		);
	end

	// output register: patch the special cases
	logic done_q;
	hsv_t result_q;
	div_t fin;

	assign fin = div_d[DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_v[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		result_q.hue        <= fin.hue_valid ? fin.hue_quo : '0;
		result_q.brightness <= fin.max_val;
		result_q.hue_valid  <= fin.hue_valid;
		if (fin.black) begin
			result_q.saturation <= '0;
		end else if (fin.sat_full) begin
			result_q.saturation <= '1;
		end else begin
			result_q.saturation <= fin.sat_quo;
		end
	end

	assign busy   = 1'b0;
	assign done   = done_q;
	assign result = result_q;

endmodule
